### sv/aes256_pkg.sv
// Package with AES-256 types, the S-box and round helper functions.
package aes256_pkg;

   localparam int BlockWidth = 128;
   localparam int KeyWidth   = 256;
   localparam int WordWidth  = 64;
   localparam int NumRounds  = 14;
   localparam int CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_KEY_WORD0 = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_WORD1 = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_WORD2 = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_WORD3 = 2'd3;

   localparam logic [7:0] GfPoly    = 8'h1B;
   localparam logic [7:0] RconFirst = 8'h01;

   typedef logic [BlockWidth-1:0] block_type;
   typedef logic [KeyWidth-1:0]   key_type;
   typedef logic [NumRounds:0]    valid_vec_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] r;
      case (x)
         8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
         8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
         8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
         8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
         8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
         8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
         8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
         8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
         8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
         8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
         8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
         8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
         8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
         8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
         8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
         8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
         8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
         8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
         8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
         8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
         8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
         8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
         8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
         8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
         8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
         8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
         8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
         8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
         8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
         8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
         8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
         8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
         8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
         8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
         8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
         8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
         8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
         8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
         8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
         8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
         8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
         8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
         8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
         8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
         8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
         8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
         8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
         8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
         8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
         8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
         8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
         8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
         8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? GfPoly : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // Byte n of a block sits in bits 127-8n downto 120-8n; state byte r+4c.
   function automatic logic [7:0] get_byte(input block_type b, input int n);
      return b[BlockWidth-1-8*n -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[BlockWidth-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
         end
      end
      return t;
   endfunction

   function automatic block_type mix_cols(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0  = get_byte(s, 4*c);
         a1  = get_byte(s, 4*c+1);
         a2  = get_byte(s, 4*c+2);
         a3  = get_byte(s, 4*c+3);
         all = a0 ^ a1 ^ a2 ^ a3;
         t[BlockWidth-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[BlockWidth-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[BlockWidth-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[BlockWidth-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

endpackage

### sv/aes256_block_encrypt_top.sv
// Top level of the pipelined AES-256 block encryption engine.
// Usage:
//   Load the 256-bit key through the csr_ port (csr_write, csr_index, csr_data);
//   index 0..3 select key words 0..3, other indices are ignored. Write the
//   key only while no transaction is in flight.
//   A plaintext transaction is accepted when start is high and busy is low.
//   busy is always low: one block can enter every clock cycle.
//   The ciphertext appears on rsp_cipher_high/low with rsp_valid high for one
//   cycle, when the block leaves the last round stage. There are 15 register
//   stages: the initial AddRoundKey, registered by the accepting edge, and
//   one per round for the 14 rounds.
//   Throughput is one block per cycle; the latency is set by the 15 stages of
//   the unrolled pipeline. Rounds 2 to 14 each carry their own key-expansion
//   step; round 1 uses the loaded key words 4..7 directly.
//   The receiver cannot stall; results are never held back.
//   Synchronous reset clears the key registers to zero and empties the
//   pipeline.
module aes256_block_encrypt_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [aes256_pkg::WordWidth-1:0]    req_plain_high,
   input  logic [aes256_pkg::WordWidth-1:0]    req_plain_low,
   output logic                                rsp_valid,
   output logic [aes256_pkg::WordWidth-1:0]    rsp_cipher_high,
   output logic [aes256_pkg::WordWidth-1:0]    rsp_cipher_low,
   input  logic                                csr_write,
   input  logic [aes256_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [aes256_pkg::WordWidth-1:0]    csr_data
);
   import aes256_pkg::*;

   logic [WordWidth-1:0] key0_ff, key1_ff, key2_ff, key3_ff;
   valid_vec_type        valid;
   block_type            state [NumRounds+1];
   key_type              rkey  [NumRounds+1];
   logic                 valid0_ff;
   block_type            state0_ff;
   key_type              key0s_ff;
   key_type              key_all;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         key3_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KEY_WORD0: key0_ff <= csr_data;
            CSR_KEY_WORD1: key1_ff <= csr_data;
            CSR_KEY_WORD2: key2_ff <= csr_data;
            CSR_KEY_WORD3: key3_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign key_all = {key0_ff, key1_ff, key2_ff, key3_ff};
   assign busy    = 1'b0;

   // Stage 0: initial AddRoundKey with the first 128 key bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= start & ~busy;
      end
      state0_ff <= {req_plain_high, req_plain_low} ^ key_all[255:128];
      // The whole key, words w[0..7], travels with the block.
      key0s_ff  <= key_all;
   end

   assign valid[0] = valid0_ff;
   assign state[0] = state0_ff;
   // Round 1 uses key words 4..7, which are already in the loaded key, so
   // expansion starts with round 2.
   assign rkey[0]  = key0s_ff;

   // Round r uses words 4r..4r+3. Stage r receives window w[4r-8..4r-1]
   // (rkey index r-1) except round 1, which is taken directly.
   block_type r1_state;
   always_comb begin
      r1_state = mix_cols(sub_shift(state[0])) ^ rkey[0][127:0];
   end

   logic      valid1_ff;
   block_type state1_ff;
   key_type   key1s_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= valid[0];
      end
      state1_ff <= r1_state;
      key1s_ff  <= rkey[0];
   end
   assign valid[1] = valid1_ff;
   assign state[1] = state1_ff;
   assign rkey[1]  = key1s_ff;

   logic [7:0] rcon_tab [NumRounds+1];
   always_comb begin
      rcon_tab[0] = RconFirst;
      for (int i = 1; i <= NumRounds; i++) begin
         rcon_tab[i] = rcon_tab[i-1];
      end
      // Rcon advances every second round (even rounds generate words 8k).
      for (int r = 2; r <= NumRounds; r++) begin
         rcon_tab[r] = RconFirst;
         for (int k = 0; k < (r/2) - 1; k++) begin
            rcon_tab[r] = xtime(rcon_tab[r]);
         end
      end
   end

   for (genvar r = 2; r <= NumRounds; r++) begin : g_round
      aes256_round u_round (
         .clock       (clock),
         .reset       (reset),
         .valid_in    (valid[r-1]),
         .final_round (r == NumRounds),
         .rcon        (rcon_tab[r]),
         .even_half   ((r % 2) == 0),
         .state_in    (state[r-1]),
         .key_in      (rkey[r-1]),
         .valid_out   (valid[r]),
         .state_out   (state[r]),
         .key_out     (rkey[r])
      );
   end

   assign rsp_valid       = valid[NumRounds];
   assign rsp_cipher_high = state[NumRounds][BlockWidth-1:WordWidth];
   assign rsp_cipher_low  = state[NumRounds][WordWidth-1:0];

   // A valid bit in stage one or in the last stage implies a valid stage before it; busy never rises.
   assert property (@(posedge clock) disable iff (reset)
      valid[1] |-> $past(valid0_ff))
      else $error("stage one valid without stage zero");
   assert property (@(posedge clock) disable iff (reset)
      busy == 1'b0)
      else $error("engine reported busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(valid[NumRounds-1]))
      else $error("result without a transaction in the last round");
endmodule

### sv/aes256_key_exp.sv
// One combinational AES-256 key expansion step: the current eight key words travel with each block.
module aes256_key_exp (
   input  logic [7:0]          rcon,
   input  logic                even_half,
   input  aes256_pkg::key_type key_in,
   output aes256_pkg::key_type key_out
);
   import aes256_pkg::*;

   // key_in holds words w[i-8..i-1]; key_out holds w[i-4..i+3].
   logic [31:0] w_new [4];
   logic [31:0] tmp;

   always_comb begin
      tmp = key_in[31:0];
      if (even_half) begin
         tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon, 24'h0};
      end else begin
         tmp = sub_word(tmp);
      end
      w_new[0] = key_in[255:224] ^ tmp;
      w_new[1] = key_in[223:192] ^ w_new[0];
      w_new[2] = key_in[191:160] ^ w_new[1];
      w_new[3] = key_in[159:128] ^ w_new[2];
   end

   assign key_out = {key_in[127:0], w_new[0], w_new[1], w_new[2], w_new[3]};
endmodule

### sv/aes256_round.sv
// One registered AES round stage: round transform, AddRoundKey and the next key step.
module aes256_round (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  logic                  final_round,
   input  logic [7:0]            rcon,
   input  logic                  even_half,
   input  aes256_pkg::block_type state_in,
   input  aes256_pkg::key_type   key_in,
   output logic                  valid_out,
   output aes256_pkg::block_type state_out,
   output aes256_pkg::key_type   key_out
);
   import aes256_pkg::*;

   // The round key for this stage is the four newly expanded words, the lower half.
   block_type state_in_x, state_ff;
   key_type   key_in_x, key_ff;
   logic      valid_ff;
   block_type shifted;

   aes256_key_exp u_kexp (
      .rcon      (rcon),
      .even_half (even_half),
      .key_in    (key_in),
      .key_out   (key_in_x)
   );

   always_comb begin
      shifted = sub_shift(state_in);
      if (!final_round) begin
         shifted = mix_cols(shifted);
      end
      state_in_x = shifted ^ key_in_x[127:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      state_ff <= state_in_x;
      key_ff   <= key_in_x;
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;
endmodule

### tb/sv/tb.sv
// Testbench for the AES-256 block encryption engine with its own cipher predictor.
`timescale 1ns / 100ps

module tb;
   import aes256_pkg::*;

   class cipher_scoreboard;
      logic [127:0] pending_cipher[$];
      int mismatches;
      int checked;

      function void note_block(input logic [127:0] cipher);
         pending_cipher.push_back(cipher);
      endfunction

      function void check_block(input logic [63:0] got_high, input logic [63:0] got_low);
         logic [127:0] want;
         if (pending_cipher.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected ciphertext %h_%h with nothing pending", got_high, got_low);
            return;
         end
         want = pending_cipher.pop_front();
         checked++;
         if (want[127:64] !== got_high || want[63:0] !== got_low) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Ciphertext mismatch: expected %h_%h, got %h_%h",
                        want[127:64], want[63:0], got_high, got_low);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [63:0] req_plain_high;
   logic [63:0] req_plain_low;
   logic rsp_valid;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic csr_write;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [63:0] csr_data;

   logic [7:0] subst_tab[256];
   logic [63:0] key_reg[4];
   int sender_idle_pct;
   int blocks_sent;
   cipher_scoreboard board;

   aes256_block_encrypt_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_plain_high(req_plain_high), .req_plain_low(req_plain_low),
      .rsp_valid(rsp_valid), .rsp_cipher_high(rsp_cipher_high),
      .rsp_cipher_low(rsp_cipher_low), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [7:0] gf_dbl(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ a;
         a = gf_dbl(a);
      end
      return acc;
   endfunction

   // The substitution table is derived from the field inverse and the affine map.
   function automatic logic [7:0] subst_calc(input logic [7:0] x);
      logic [7:0] inv;
      logic [7:0] b;
      inv = 8'h01;
      for (int i = 0; i < 254; i++) inv = gf_mul(inv, x);
      b = (x == 8'h00) ? 8'h00 : inv;
      return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
             ^ {b[3:0], b[7:4]} ^ 8'h63;
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [255:0] key,
                                                   input logic [127:0] plain);
      logic [31:0] w[60];
      logic [31:0] t;
      logic [7:0] rc;
      logic [127:0] s;
      logic [127:0] u;
      logic [7:0] a0, a1, a2, a3, all;
      rc = 8'h01;
      for (int i = 0; i < 8; i++) w[i] = key[255-32*i -: 32];
      for (int i = 8; i < 60; i++) begin
         t = w[i-1];
         if (i % 8 == 0) begin
            t = {subst_tab[t[23:16]] ^ rc, subst_tab[t[15:8]], subst_tab[t[7:0]],
                 subst_tab[t[31:24]]};
            rc = gf_dbl(rc);
         end else if (i % 8 == 4) begin
            t = {subst_tab[t[31:24]], subst_tab[t[23:16]], subst_tab[t[15:8]],
                 subst_tab[t[7:0]]};
         end
         w[i] = w[i-8] ^ t;
      end
      s = plain ^ {w[0], w[1], w[2], w[3]};
      for (int r = 1; r <= 14; r++) begin
         // Byte q+4c of the state is block byte q+4c; row q rotates left by q.
         for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++)
               u[127-8*(q+4*c) -: 8] = subst_tab[s[127-8*(q+4*((c+q)%4)) -: 8]];
         s = u;
         if (r < 14) begin
            for (int c = 0; c < 4; c++) begin
               a0 = u[127-32*c -: 8];
               a1 = u[119-32*c -: 8];
               a2 = u[111-32*c -: 8];
               a3 = u[103-32*c -: 8];
               all = a0 ^ a1 ^ a2 ^ a3;
               s[127-32*c -: 8] = a0 ^ all ^ gf_dbl(a0 ^ a1);
               s[119-32*c -: 8] = a1 ^ all ^ gf_dbl(a1 ^ a2);
               s[111-32*c -: 8] = a2 ^ all ^ gf_dbl(a2 ^ a3);
               s[103-32*c -: 8] = a3 ^ all ^ gf_dbl(a3 ^ a0);
            end
         end
         s = s ^ {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
      end
      return s;
   endfunction

   // Accepted transactions and results are both observed at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_block(encrypt_block({key_reg[0], key_reg[1], key_reg[2], key_reg[3]},
                                           {req_plain_high, req_plain_low}));
            blocks_sent++;
         end
         if (rsp_valid) board.check_block(rsp_cipher_high, rsp_cipher_low);
         if (csr_write) key_reg[csr_index] <= csr_data;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
      int gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(4, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_plain_high <= hi;
      req_plain_low <= lo;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending_cipher.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
      logic [63:0] words[4];
      words = '{k0, k1, k2, k3};
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= i[CsrIdxWidth-1:0];
         csr_data <= words[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int count, input int idle_pct);
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 && idle_pct > 0) drain();
         send_block(rand64(), rand64());
      end
   endtask

   initial begin
      board = new();
      for (int i = 0; i < 256; i++) subst_tab[i] = subst_calc(i[7:0]);
      for (int i = 0; i < 4; i++) key_reg[i] = 64'h0;
      blocks_sent = 0;
      sender_idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_plain_high = 64'h0;
      req_plain_low = 64'h0;
      csr_write = 1'b0;
      csr_index = CSR_KEY_WORD0;
      csr_data = 64'h0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The all-zero key after reset is a valid key.
      send_block(64'h0, 64'h0);
      send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_block(64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
      load_key(64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F,
               64'h1011_1213_1415_1617, 64'h1819_1A1B_1C1D_1E1F);
      send_block(64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
      send_block(64'h0, 64'h0);
      send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
      send_block(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
      load_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_block(64'h0, 64'h0);
      send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

      random_phase(450, 0);
      load_key(rand64(), rand64(), rand64(), rand64());
      random_phase(450, 63);
      load_key(64'h0, 64'h0, 64'h0, 64'h0);
      random_phase(450, 28);
      load_key(rand64(), rand64(), rand64(), rand64());
      random_phase(450, 0);

      drain();
      $display("Encrypted %0d blocks under six keys (zero, all ones, standard, random),",
               blocks_sent);
      $display("with back-to-back traffic and random sender gaps; %0d results checked.",
               board.checked);
      if (board.mismatches == 0 && board.pending_cipher.size() == 0)
         $display("** aes256_block_encrypt_top: PASSED **");
      else
         $display("** aes256_block_encrypt_top: FAILED **");
      $finish;
   end

   initial begin
      #400000;
      $display("Timeout with %0d results outstanding.", board.pending_cipher.size());
      $display("** aes256_block_encrypt_top: FAILED **");
      $finish;
   end

endmodule

### sim.f
sv/aes256_pkg.sv
sv/aes256_key_exp.sv
sv/aes256_round.sv
sv/aes256_block_encrypt_top.sv
tb/sv/tb.sv
